// ----- hdl/adf_pkg.sv -----
// Shared types, codes and constants of the alarm, deadband and fan-out block.
`default_nettype none

package adf_pkg;

    localparam int PORT_COUNT_DEF = 8;
    localparam int OUT_PORTS      = 8;
    localparam int SAMPLE_W       = 32;
    localparam int BAND_W         = 31;
    localparam int MODES_W        = 10;
    localparam int SELECT_W       = 16;
    localparam int ADDR_W         = 5;
    localparam int DATA_W         = 32;

    typedef enum logic [2:0] {
        ALM_NONE  = 3'd0,
        ALM_UNDEF = 3'd1,
        ALM_HIHI  = 3'd2,
        ALM_LOLO  = 3'd3,
        ALM_HIGH  = 3'd4,
        ALM_LOW   = 3'd5,
        ALM_SOFT  = 3'd6,
        ALM_LINK  = 3'd7
    } alarm_code_t;

    typedef enum logic [1:0] {
        SEV_NONE    = 2'd0,
        SEV_MINOR   = 2'd1,
        SEV_MAJOR   = 2'd2,
        SEV_INVALID = 2'd3
    } severity_t;

    typedef enum logic [1:0] {
        SEL_ALL     = 2'd0,
        SEL_NUMBER  = 2'd1,
        SEL_BITMASK = 2'd2,
        SEL_INVALID = 2'd3
    } select_mode_t;

    typedef enum logic [2:0] {
        REG_HIHI     = 3'd0,
        REG_HIGH     = 3'd1,
        REG_LOW      = 3'd2,
        REG_LOLO     = 3'd3,
        REG_HYST     = 3'd4,
        REG_MODES    = 3'd5,
        REG_VALUE_DB = 3'd6,
        REG_ARCH_DB  = 3'd7
    } reg_index_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] hihi_limit;
        logic signed [SAMPLE_W-1:0] high_limit;
        logic signed [SAMPLE_W-1:0] low_limit;
        logic signed [SAMPLE_W-1:0] lolo_limit;
        logic        [BAND_W-1:0]   hysteresis;
        logic        [MODES_W-1:0]  alarm_modes;
        logic        [BAND_W-1:0]   value_deadband;
        logic        [BAND_W-1:0]   archive_deadband;
    } cfg_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] last_alarm_level;
        logic signed [SAMPLE_W-1:0] last_posted_value;
        logic signed [SAMPLE_W-1:0] last_archived_value;
        alarm_code_t                previous_alarm_code;
        severity_t                  previous_severity;
    } state_t;

    typedef struct packed {
        logic        [OUT_PORTS-1:0] port_mask;
        alarm_code_t                 alarm_code;
        severity_t                   alarm_severity;
        logic                        value_event;
        logic                        archive_event;
        logic                        alarm_event;
    } result_t;

endpackage

`default_nettype wire

// ----- hdl/adf_cfg.sv -----
// Configuration register file behind the APB-style port.
`default_nettype none

module adf_cfg (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [adf_pkg::ADDR_W-1:0] paddr,
    input  wire logic [adf_pkg::DATA_W-1:0] pwdata,
    output logic      [adf_pkg::DATA_W-1:0] prdata,
    output logic                            pready,
    output adf_pkg::cfg_t                   cfg
);

    adf_pkg::cfg_t      cfg_reg;
    adf_pkg::reg_index_t index;
    logic               write_en;

    assign pready   = 1'b1;
    assign index    = adf_pkg::reg_index_t'(paddr[adf_pkg::ADDR_W-1:2]);
    assign write_en = psel && penable && pwrite && pready;
    assign cfg      = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (write_en)
        begin
            case (index)
                adf_pkg::REG_HIHI:     cfg_reg.hihi_limit       <= pwdata;
                adf_pkg::REG_HIGH:     cfg_reg.high_limit       <= pwdata;
                adf_pkg::REG_LOW:      cfg_reg.low_limit        <= pwdata;
                adf_pkg::REG_LOLO:     cfg_reg.lolo_limit       <= pwdata;
                adf_pkg::REG_HYST:     cfg_reg.hysteresis       <= pwdata[adf_pkg::BAND_W-1:0];
                adf_pkg::REG_MODES:    cfg_reg.alarm_modes      <= pwdata[adf_pkg::MODES_W-1:0];
                adf_pkg::REG_VALUE_DB: cfg_reg.value_deadband   <= pwdata[adf_pkg::BAND_W-1:0];
                adf_pkg::REG_ARCH_DB:  cfg_reg.archive_deadband <= pwdata[adf_pkg::BAND_W-1:0];
                default:               cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (index)
            adf_pkg::REG_HIHI:     prdata = cfg_reg.hihi_limit;
            adf_pkg::REG_HIGH:     prdata = cfg_reg.high_limit;
            adf_pkg::REG_LOW:      prdata = cfg_reg.low_limit;
            adf_pkg::REG_LOLO:     prdata = cfg_reg.lolo_limit;
            adf_pkg::REG_HYST:     prdata = {1'b0, cfg_reg.hysteresis};
            adf_pkg::REG_MODES:
                prdata = {{(adf_pkg::DATA_W-adf_pkg::MODES_W){1'b0}}, cfg_reg.alarm_modes};
            adf_pkg::REG_VALUE_DB: prdata = {1'b0, cfg_reg.value_deadband};
            adf_pkg::REG_ARCH_DB:  prdata = {1'b0, cfg_reg.archive_deadband};
            default:               prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ----- hdl/adf_eval.sv -----
// Alarm, fan-out and deadband evaluation of one sample against the stored state.
`default_nettype none

module adf_eval #(
    parameter int PORT_COUNT = adf_pkg::PORT_COUNT_DEF
) (
    input  wire logic signed [adf_pkg::SAMPLE_W-1:0]  sample,
    input  wire logic                                 sample_undefined,
    input  wire logic        [adf_pkg::SELECT_W-1:0]  select_number,
    input  wire logic        [adf_pkg::OUT_PORTS-1:0] write_fail_mask,
    input  wire adf_pkg::cfg_t                        cfg,
    input  wire adf_pkg::state_t                      state,
    output adf_pkg::result_t                          result,
    output adf_pkg::state_t                           state_next
);

    localparam int EXT_W = adf_pkg::SAMPLE_W + 2;

    logic signed [EXT_W-1:0] val_x;
    logic signed [EXT_W-1:0] hyst_x;
    logic signed [EXT_W-1:0] hihi_x;
    logic signed [EXT_W-1:0] high_x;
    logic signed [EXT_W-1:0] low_x;
    logic signed [EXT_W-1:0] lolo_x;
    logic                    hihi_hit;
    logic                    lolo_hit;
    logic                    high_hit;
    logic                    low_hit;
    logic [1:0]              hihi_sev;
    logic [1:0]              lolo_sev;
    logic [1:0]              high_sev;
    logic [1:0]              low_sev;
    adf_pkg::select_mode_t   mode;
    logic [adf_pkg::OUT_PORTS-1:0] sel;
    logic                    soft_fault;
    adf_pkg::alarm_code_t    code;
    adf_pkg::severity_t      sev;
    logic signed [EXT_W-1:0] pdiff;
    logic signed [EXT_W-1:0] adiff;
    logic signed [EXT_W-1:0] vband;
    logic signed [EXT_W-1:0] aband;
    logic                    vev;
    logic                    aev;

    assign hihi_sev = cfg.alarm_modes[1:0];
    assign lolo_sev = cfg.alarm_modes[3:2];
    assign high_sev = cfg.alarm_modes[5:4];
    assign low_sev  = cfg.alarm_modes[7:6];
    assign mode     = adf_pkg::select_mode_t'(cfg.alarm_modes[9:8]);

    assign val_x  = EXT_W'(sample);
    assign hyst_x = EXT_W'({1'b0, cfg.hysteresis});
    assign hihi_x = EXT_W'(cfg.hihi_limit);
    assign high_x = EXT_W'(cfg.high_limit);
    assign low_x  = EXT_W'(cfg.low_limit);
    assign lolo_x = EXT_W'(cfg.lolo_limit);

    assign hihi_hit = (hihi_sev != 2'd0) && ((val_x >= hihi_x) ||
        ((state.last_alarm_level == cfg.hihi_limit) && (val_x >= hihi_x - hyst_x)));
    assign lolo_hit = (lolo_sev != 2'd0) && ((val_x <= lolo_x) ||
        ((state.last_alarm_level == cfg.lolo_limit) && (val_x <= lolo_x + hyst_x)));
    assign high_hit = (high_sev != 2'd0) && ((val_x >= high_x) ||
        ((state.last_alarm_level == cfg.high_limit) && (val_x >= high_x - hyst_x)));
    assign low_hit  = (low_sev != 2'd0) && ((val_x <= low_x) ||
        ((state.last_alarm_level == cfg.low_limit) && (val_x <= low_x + hyst_x)));

    always_comb
    begin
        sel        = '0;
        soft_fault = 1'b0;
        case (mode)
            adf_pkg::SEL_ALL:
            begin
                for (int i = 0; i < adf_pkg::OUT_PORTS; i++)
                begin
                    sel[i] = (i < PORT_COUNT);
                end
            end
            adf_pkg::SEL_NUMBER:
            begin
                soft_fault = select_number > adf_pkg::SELECT_W'(PORT_COUNT);
                for (int i = 0; i < adf_pkg::OUT_PORTS; i++)
                begin
                    sel[i] = (i < PORT_COUNT) &&
                             (select_number == adf_pkg::SELECT_W'(i + 1));
                end
            end
            adf_pkg::SEL_BITMASK:
            begin
                for (int i = 0; i < adf_pkg::OUT_PORTS; i++)
                begin
                    sel[i] = (i < PORT_COUNT) && select_number[i];
                end
            end
            default:
            begin
                soft_fault = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        code                        = adf_pkg::ALM_NONE;
        sev                         = adf_pkg::SEV_NONE;
        state_next.last_alarm_level = state.last_alarm_level;
        if (sample_undefined)
        begin
            code = adf_pkg::ALM_UNDEF;
            sev  = adf_pkg::SEV_INVALID;
        end
        else if (hihi_hit)
        begin
            code                        = adf_pkg::ALM_HIHI;
            sev                         = adf_pkg::severity_t'(hihi_sev);
            state_next.last_alarm_level = cfg.hihi_limit;
        end
        else if (lolo_hit)
        begin
            code                        = adf_pkg::ALM_LOLO;
            sev                         = adf_pkg::severity_t'(lolo_sev);
            state_next.last_alarm_level = cfg.lolo_limit;
        end
        else if (high_hit)
        begin
            code                        = adf_pkg::ALM_HIGH;
            sev                         = adf_pkg::severity_t'(high_sev);
            state_next.last_alarm_level = cfg.high_limit;
        end
        else if (low_hit)
        begin
            code                        = adf_pkg::ALM_LOW;
            sev                         = adf_pkg::severity_t'(low_sev);
            state_next.last_alarm_level = cfg.low_limit;
        end
        else
        begin
            state_next.last_alarm_level = sample;
        end

        if (soft_fault && (sev != adf_pkg::SEV_INVALID))
        begin
            code = adf_pkg::ALM_SOFT;
            sev  = adf_pkg::SEV_INVALID;
        end
        if (((sel & write_fail_mask) != '0) &&
            ((sev == adf_pkg::SEV_NONE) || (sev == adf_pkg::SEV_MINOR)))
        begin
            code = adf_pkg::ALM_LINK;
            sev  = adf_pkg::SEV_MAJOR;
        end

        state_next.last_posted_value   = vev ? sample : state.last_posted_value;
        state_next.last_archived_value = aev ? sample : state.last_archived_value;
        state_next.previous_alarm_code = code;
        state_next.previous_severity   = sev;
    end

    assign pdiff = val_x - EXT_W'(state.last_posted_value);
    assign adiff = val_x - EXT_W'(state.last_archived_value);
    assign vband = EXT_W'({1'b0, cfg.value_deadband});
    assign aband = EXT_W'({1'b0, cfg.archive_deadband});
    assign vev   = (pdiff > vband) || (pdiff < -vband);
    assign aev   = (adiff > aband) || (adiff < -aband);

    assign result.port_mask      = sel;
    assign result.alarm_code     = code;
    assign result.alarm_severity = sev;
    assign result.value_event    = vev;
    assign result.archive_event  = aev;
    assign result.alarm_event    = (code != state.previous_alarm_code) ||
                                   (sev != state.previous_severity);

endmodule

`default_nettype wire

// ----- hdl/alarm_deadband_fanout.sv -----
// Top level: four-level alarm with hysteresis, deadband events and output fan-out.
//
//  Channel   Handshake                    Payload
//  sample    sample_valid / sample_stall  sample, sample_undefined, select_number,
//                                         write_fail_mask
//  result    result_valid / result_stall  out_sample, port_mask, alarm_code,
//                                         alarm_severity, value_event, archive_event,
//                                         alarm_event
//  config    psel / penable / pready      paddr, pwdata, pwrite, prdata
//
// A transaction is held in the input register and evaluated there against the
// stored alarm and deadband state; the result register takes it once that register is empty
// or result_stall is low. One transaction is accepted every cycle while sample_stall
// is low. The stored state is updated when a transaction moves into the result
// register. Reset clears the configuration, the stored state and both valid flags.
// sample_stall rises only when both registers are full and result_stall is high.
`default_nettype none

module alarm_deadband_fanout #(
    parameter int PORT_COUNT = adf_pkg::PORT_COUNT_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic        [adf_pkg::ADDR_W-1:0]  paddr,
    input  wire logic        [adf_pkg::DATA_W-1:0]  pwdata,
    output logic             [adf_pkg::DATA_W-1:0]  prdata,
    output logic                                    pready,
    input  wire logic                               sample_valid,
    output logic                                    sample_stall,
    input  wire logic signed [adf_pkg::SAMPLE_W-1:0] sample,
    input  wire logic                               sample_undefined,
    input  wire logic        [adf_pkg::SELECT_W-1:0] select_number,
    input  wire logic        [adf_pkg::OUT_PORTS-1:0] write_fail_mask,
    output logic                                    result_valid,
    input  wire logic                               result_stall,
    output logic signed      [adf_pkg::SAMPLE_W-1:0] out_sample,
    output logic             [adf_pkg::OUT_PORTS-1:0] port_mask,
    output logic             [2:0]                  alarm_code,
    output logic             [1:0]                  alarm_severity,
    output logic                                    value_event,
    output logic                                    archive_event,
    output logic                                    alarm_event
);

    adf_pkg::cfg_t    cfg;
    adf_pkg::state_t  state_reg;
    adf_pkg::state_t  state_next;
    adf_pkg::result_t eval_result;
    adf_pkg::result_t res_reg;

    logic                                s1_valid_reg;
    logic                                s1_valid_next;
    logic signed [adf_pkg::SAMPLE_W-1:0] s1_sample_reg;
    logic                                s1_undef_reg;
    logic [adf_pkg::SELECT_W-1:0]        s1_select_reg;
    logic [adf_pkg::OUT_PORTS-1:0]       s1_fail_reg;
    logic                                res_valid_reg;
    logic                                res_valid_next;
    logic signed [adf_pkg::SAMPLE_W-1:0] res_sample_reg;
    logic                                s1_move;
    logic                                accept;

    adf_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    adf_eval #(
        .PORT_COUNT (PORT_COUNT)
    ) u_eval (
        .sample           (s1_sample_reg),
        .sample_undefined (s1_undef_reg),
        .select_number    (s1_select_reg),
        .write_fail_mask  (s1_fail_reg),
        .cfg              (cfg),
        .state            (state_reg),
        .result           (eval_result),
        .state_next       (state_next)
    );

    assign s1_move        = s1_valid_reg && (!res_valid_reg || !result_stall);
    assign sample_stall   = s1_valid_reg && !s1_move;
    assign accept         = sample_valid && !sample_stall;
    assign s1_valid_next  = accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_reg);
    assign res_valid_next = s1_move ? 1'b1 : (result_stall ? res_valid_reg : 1'b0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            res_valid_reg <= res_valid_next;
            if (s1_move)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sample_reg <= sample;
            s1_undef_reg  <= sample_undefined;
            s1_select_reg <= select_number;
            s1_fail_reg   <= write_fail_mask;
        end
        if (s1_move)
        begin
            res_reg        <= eval_result;
            res_sample_reg <= s1_sample_reg;
        end
    end

    assign result_valid   = res_valid_reg;
    assign out_sample     = res_sample_reg;
    assign port_mask      = res_reg.port_mask;
    assign alarm_code     = res_reg.alarm_code;
    assign alarm_severity = res_reg.alarm_severity;
    assign value_event    = res_reg.value_event;
    assign archive_event  = res_reg.archive_event;
    assign alarm_event    = res_reg.alarm_event;

`ifndef SYNTHESIS
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> (s1_valid_reg && res_valid_reg && result_stall))
        else $error("input stalled while a register was free");

    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_move |=> $stable(state_reg))
        else $error("stored state changed without a transaction");

    a_result_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
        s1_move |=> (res_valid_reg && (out_sample == $past(s1_sample_reg))))
        else $error("result register missed a transaction");

    a_none_code: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && (res_reg.alarm_severity == adf_pkg::SEV_NONE))
            |-> (res_reg.alarm_code == adf_pkg::ALM_NONE))
        else $error("alarm code without severity");

    a_soft_invalid: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && (res_reg.alarm_code == adf_pkg::ALM_SOFT))
            |-> (res_reg.alarm_severity == adf_pkg::SEV_INVALID))
        else $error("soft alarm below invalid severity");
`endif

endmodule

`default_nettype wire

// ----- dv/alarm_deadband_fanout_test.sv -----
// Self-checking testbench for alarm_deadband_fanout: directed and random transactions.
`timescale 1ns / 100ps

module alarm_deadband_fanout_test;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_AT = 300;
    localparam int HOLD_CYCLES = 300;
    localparam int RANDOM_PER_PHASE = 206;
    localparam int PRINT_CAP = 40;

    typedef struct packed {
        logic signed [adf_pkg::SAMPLE_W-1:0] value;
        logic                                undefined;
        logic [adf_pkg::SELECT_W-1:0]        select_number;
        logic [adf_pkg::OUT_PORTS-1:0]       fail_mask;
    } sample_item_t;

    typedef struct packed {
        logic signed [adf_pkg::SAMPLE_W-1:0] out_sample;
        adf_pkg::result_t                    res;
    } fanout_result_t;

    logic clk;
    logic rst_n = 1'b0;

    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [adf_pkg::ADDR_W-1:0] paddr = '0;
    logic [adf_pkg::DATA_W-1:0] pwdata = '0;
    logic [adf_pkg::DATA_W-1:0] prdata;
    logic pready;

    logic sample_valid = 1'b0;
    logic sample_stall;
    logic signed [adf_pkg::SAMPLE_W-1:0] sample = '0;
    logic sample_undefined = 1'b0;
    logic [adf_pkg::SELECT_W-1:0] select_number = '0;
    logic [adf_pkg::OUT_PORTS-1:0] write_fail_mask = '0;

    logic result_valid;
    logic result_stall = 1'b0;
    logic signed [adf_pkg::SAMPLE_W-1:0] out_sample;
    logic [adf_pkg::OUT_PORTS-1:0] port_mask;
    logic [2:0] alarm_code;
    logic [1:0] alarm_severity;
    logic value_event;
    logic archive_event;
    logic alarm_event;

    adf_pkg::cfg_t shadow_cfg = '0;
    logic signed [adf_pkg::SAMPLE_W-1:0] level_last = '0;
    logic signed [adf_pkg::SAMPLE_W-1:0] posted_last = '0;
    logic signed [adf_pkg::SAMPLE_W-1:0] archived_last = '0;
    adf_pkg::alarm_code_t prev_code = adf_pkg::ALM_NONE;
    adf_pkg::severity_t prev_sev = adf_pkg::SEV_NONE;

    sample_item_t pending_items[$];
    fanout_result_t predicted_results[$];
    sample_item_t offered_item;
    bit offer_open = 1'b0;
    logic signed [adf_pkg::SAMPLE_W-1:0] recent_sample = '0;

    int accepted_total = 0;
    int results_checked = 0;
    int mismatch_count = 0;
    int settings_count = 0;
    int cycle_count = 0;
    int burst_left = 0;
    int gap_left = 0;
    int stall_style = 0;
    int stall_seg_left = 0;
    int hold_left = 0;
    bit long_hold_done = 1'b0;

    alarm_deadband_fanout dut (
        .clk(clk),
        .rst_n(rst_n),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready),
        .sample_valid(sample_valid),
        .sample_stall(sample_stall),
        .sample(sample),
        .sample_undefined(sample_undefined),
        .select_number(select_number),
        .write_fail_mask(write_fail_mask),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .out_sample(out_sample),
        .port_mask(port_mask),
        .alarm_code(alarm_code),
        .alarm_severity(alarm_severity),
        .value_event(value_event),
        .archive_event(archive_event),
        .alarm_event(alarm_event)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    function automatic logic signed [adf_pkg::SAMPLE_W-1:0] q16(int whole);
        return whole * 65536;
    endfunction

    function automatic logic signed [adf_pkg::SAMPLE_W-1:0] clamp_s32(longint x);
        if (x > 64'sd2147483647)
            return 32'sh7FFFFFFF;
        if (x < -64'sd2147483648)
            return 32'sh80000000;
        return x[31:0];
    endfunction

    function automatic void raise_alarm_to(inout adf_pkg::alarm_code_t code,
                                           inout adf_pkg::severity_t sev,
                                           input adf_pkg::alarm_code_t new_code,
                                           input adf_pkg::severity_t new_sev);
        if (new_sev > sev)
        begin
            code = new_code;
            sev = new_sev;
        end
    endfunction

    task automatic predict_alarm_fanout(input sample_item_t it, output fanout_result_t out);
        adf_pkg::alarm_code_t code;
        adf_pkg::severity_t sev;
        logic signed [adf_pkg::SAMPLE_W-1:0] chk_lim [4];
        adf_pkg::severity_t chk_sev [4];
        adf_pkg::alarm_code_t chk_code [4];
        bit chk_upper [4];
        bit tripped;
        bit held;
        bit hit;
        longint v;
        longint lim;
        longint hyst;
        longint d;
        logic [adf_pkg::OUT_PORTS-1:0] sel;
        chk_lim[0] = shadow_cfg.hihi_limit;
        chk_lim[1] = shadow_cfg.lolo_limit;
        chk_lim[2] = shadow_cfg.high_limit;
        chk_lim[3] = shadow_cfg.low_limit;
        chk_sev[0] = adf_pkg::severity_t'(shadow_cfg.alarm_modes[1:0]);
        chk_sev[1] = adf_pkg::severity_t'(shadow_cfg.alarm_modes[3:2]);
        chk_sev[2] = adf_pkg::severity_t'(shadow_cfg.alarm_modes[5:4]);
        chk_sev[3] = adf_pkg::severity_t'(shadow_cfg.alarm_modes[7:6]);
        chk_code[0] = adf_pkg::ALM_HIHI;
        chk_code[1] = adf_pkg::ALM_LOLO;
        chk_code[2] = adf_pkg::ALM_HIGH;
        chk_code[3] = adf_pkg::ALM_LOW;
        chk_upper[0] = 1'b1;
        chk_upper[1] = 1'b0;
        chk_upper[2] = 1'b1;
        chk_upper[3] = 1'b0;
        code = adf_pkg::ALM_NONE;
        sev = adf_pkg::SEV_NONE;
        hyst = longint'(shadow_cfg.hysteresis);
        v = longint'($signed(it.value));

        if (it.undefined)
            raise_alarm_to(code, sev, adf_pkg::ALM_UNDEF, adf_pkg::SEV_INVALID);
        else
        begin
            tripped = 1'b0;
            for (int k = 0; k < 4; k++)
            begin
                if (!tripped && chk_sev[k] != adf_pkg::SEV_NONE)
                begin
                    lim = longint'($signed(chk_lim[k]));
                    held = (longint'($signed(level_last)) == lim);
                    if (chk_upper[k])
                        hit = (v >= lim) || (held && v >= lim - hyst);
                    else
                        hit = (v <= lim) || (held && v <= lim + hyst);
                    if (hit)
                    begin
                        tripped = 1'b1;
                        if (chk_sev[k] > sev)
                            level_last = chk_lim[k];
                        raise_alarm_to(code, sev, chk_code[k], chk_sev[k]);
                    end
                end
            end
            if (!tripped)
                level_last = it.value;
        end

        sel = '0;
        case (adf_pkg::select_mode_t'(shadow_cfg.alarm_modes[9:8]))
            adf_pkg::SEL_ALL:
                sel = '1;
            adf_pkg::SEL_NUMBER:
                if (it.select_number > adf_pkg::OUT_PORTS)
                    raise_alarm_to(code, sev, adf_pkg::ALM_SOFT, adf_pkg::SEV_INVALID);
                else if (it.select_number != 0)
                    sel = 8'd1 << (it.select_number - 16'd1);
            adf_pkg::SEL_BITMASK:
                sel = it.select_number[adf_pkg::OUT_PORTS-1:0];
            default:
                raise_alarm_to(code, sev, adf_pkg::ALM_SOFT, adf_pkg::SEV_INVALID);
        endcase
        if ((sel & it.fail_mask) != 0)
            raise_alarm_to(code, sev, adf_pkg::ALM_LINK, adf_pkg::SEV_MAJOR);

        out.out_sample = it.value;
        out.res.port_mask = sel;
        out.res.alarm_code = code;
        out.res.alarm_severity = sev;

        d = longint'($signed(posted_last)) - v;
        if (d < 0)
            d = -d;
        out.res.value_event = (d > longint'(shadow_cfg.value_deadband));
        if (out.res.value_event)
            posted_last = it.value;

        d = longint'($signed(archived_last)) - v;
        if (d < 0)
            d = -d;
        out.res.archive_event = (d > longint'(shadow_cfg.archive_deadband));
        if (out.res.archive_event)
            archived_last = it.value;

        out.res.alarm_event = (code != prev_code) || (sev != prev_sev);
        prev_code = code;
        prev_sev = sev;
    endtask

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] wanted);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP)
            $display("MISMATCH at result %0d, %s: got %h, wanted %h",
                     results_checked, field, got, wanted);
    endtask

    task automatic write_register(input adf_pkg::reg_index_t idx,
                                  input logic [adf_pkg::DATA_W-1:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            adf_pkg::REG_HIHI:     shadow_cfg.hihi_limit = value;
            adf_pkg::REG_HIGH:     shadow_cfg.high_limit = value;
            adf_pkg::REG_LOW:      shadow_cfg.low_limit = value;
            adf_pkg::REG_LOLO:     shadow_cfg.lolo_limit = value;
            adf_pkg::REG_HYST:     shadow_cfg.hysteresis = value[adf_pkg::BAND_W-1:0];
            adf_pkg::REG_MODES:    shadow_cfg.alarm_modes = value[adf_pkg::MODES_W-1:0];
            adf_pkg::REG_VALUE_DB: shadow_cfg.value_deadband = value[adf_pkg::BAND_W-1:0];
            default:               shadow_cfg.archive_deadband = value[adf_pkg::BAND_W-1:0];
        endcase
    endtask

    task automatic apply_settings(input adf_pkg::cfg_t s);
        write_register(adf_pkg::REG_HIHI, s.hihi_limit);
        write_register(adf_pkg::REG_HIGH, s.high_limit);
        write_register(adf_pkg::REG_LOW, s.low_limit);
        write_register(adf_pkg::REG_LOLO, s.lolo_limit);
        write_register(adf_pkg::REG_HYST, 32'(s.hysteresis));
        write_register(adf_pkg::REG_MODES, 32'(s.alarm_modes));
        write_register(adf_pkg::REG_VALUE_DB, 32'(s.value_deadband));
        write_register(adf_pkg::REG_ARCH_DB, 32'(s.archive_deadband));
        settings_count++;
    endtask

    task automatic wait_idle();
        while (pending_items.size() != 0 || offer_open || predicted_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic queue_item(input logic signed [adf_pkg::SAMPLE_W-1:0] value,
                              input logic undefined,
                              input logic [adf_pkg::SELECT_W-1:0] seln,
                              input logic [adf_pkg::OUT_PORTS-1:0] fail);
        sample_item_t it;
        it.value = value;
        it.undefined = undefined;
        it.select_number = seln;
        it.fail_mask = fail;
        pending_items.push_back(it);
    endtask

    // Most samples land on or around a threshold so that the hysteresis hold is exercised.
    task automatic queue_random_items(input int count);
        sample_item_t it;
        longint base;
        longint hyst;
        longint sgn;
        longint x;
        int pick;
        for (int n = 0; n < count; n++)
        begin
            hyst = longint'(shadow_cfg.hysteresis);
            sgn = ($urandom_range(0, 1) != 0) ? 1 : -1;
            pick = $urandom_range(0, 99);
            case ($urandom_range(0, 3))
                0: base = longint'($signed(shadow_cfg.hihi_limit));
                1: base = longint'($signed(shadow_cfg.lolo_limit));
                2: base = longint'($signed(shadow_cfg.high_limit));
                default: base = longint'($signed(shadow_cfg.low_limit));
            endcase
            if (pick < 20)
                x = base + sgn * (hyst + longint'($urandom_range(0, 2)) - 1);
            else if (pick < 30)
                x = base + sgn * longint'($urandom_range(0, 1));
            else if (pick < 55)
                x = base + sgn * longint'($urandom_range(0, 32'(hyst + 4)));
            else if (pick < 75)
                x = longint'($signed(recent_sample)) + sgn * longint'($urandom_range(0, 1 << 20));
            else if (pick < 92)
                x = longint'($signed($urandom));
            else
            begin
                case ($urandom_range(0, 3))
                    0: x = 64'sd2147483647;
                    1: x = -64'sd2147483648;
                    2: x = 0;
                    default: x = -1;
                endcase
            end
            it.value = clamp_s32(x);
            it.undefined = ($urandom_range(0, 9) == 0);
            case ($urandom_range(0, 3))
                0: it.select_number = 16'($urandom_range(0, 9));
                1: it.select_number = 16'($urandom);
                2: it.select_number = 16'd1 << $urandom_range(0, 15);
                default: it.select_number = 16'($urandom_range(0, 255));
            endcase
            it.fail_mask = ($urandom_range(0, 1) != 0) ? 8'($urandom) : '0;
            recent_sample = it.value;
            pending_items.push_back(it);
        end
    endtask

    always @(posedge clk)
    begin : sample_driver
        fanout_result_t predicted;
        sample_item_t next_item;
        if (rst_n)
        begin
            if (sample_valid && !sample_stall)
            begin
                predict_alarm_fanout(offered_item, predicted);
                predicted_results.push_back(predicted);
                accepted_total++;
                offer_open = 1'b0;
            end
            if (!sample_valid || !sample_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    sample_valid <= 1'b0;
                end
                else if (pending_items.size() == 0)
                    sample_valid <= 1'b0;
                else
                begin
                    next_item = pending_items.pop_front();
                    offered_item = next_item;
                    offer_open = 1'b1;
                    sample <= next_item.value;
                    sample_undefined <= next_item.undefined;
                    select_number <= next_item.select_number;
                    write_fail_mask <= next_item.fail_mask;
                    sample_valid <= 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                    end
                    else
                        burst_left--;
                end
            end
        end
    end

    always @(posedge clk)
    begin : long_hold
        if (rst_n)
        begin
            if (hold_left != 0)
                hold_left <= hold_left - 1;
            else if (!long_hold_done && accepted_total >= HOLD_AT)
            begin
                hold_left <= HOLD_CYCLES;
                long_hold_done <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : result_monitor
        fanout_result_t wanted;
        bit stall_next;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (predicted_results.size() == 0)
                    report_mismatch("transaction with none predicted", out_sample, '0);
                else
                begin
                    wanted = predicted_results.pop_front();
                    if (out_sample !== wanted.out_sample)
                        report_mismatch("out_sample", out_sample, wanted.out_sample);
                    if (port_mask !== wanted.res.port_mask)
                        report_mismatch("port_mask", 32'(port_mask), 32'(wanted.res.port_mask));
                    if (alarm_code !== wanted.res.alarm_code)
                        report_mismatch("alarm_code", 32'(alarm_code), 32'(wanted.res.alarm_code));
                    if (alarm_severity !== wanted.res.alarm_severity)
                        report_mismatch("alarm_severity", 32'(alarm_severity),
                                        32'(wanted.res.alarm_severity));
                    if (value_event !== wanted.res.value_event)
                        report_mismatch("value_event", 32'(value_event),
                                        32'(wanted.res.value_event));
                    if (archive_event !== wanted.res.archive_event)
                        report_mismatch("archive_event", 32'(archive_event),
                                        32'(wanted.res.archive_event));
                    if (alarm_event !== wanted.res.alarm_event)
                        report_mismatch("alarm_event", 32'(alarm_event),
                                        32'(wanted.res.alarm_event));
                end
                results_checked++;
            end
            if (stall_seg_left == 0)
            begin
                stall_style = $urandom_range(0, 2);
                stall_seg_left = $urandom_range(10, 120);
            end
            stall_seg_left--;
            case (stall_style)
                0: stall_next = 1'b0;
                1: stall_next = ($urandom_range(0, 1) != 0);
                default: stall_next = ($urandom_range(0, 3) != 0);
            endcase
            result_stall <= stall_next || (hold_left != 0);
        end
    end

    always @(posedge clk)
    begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin : stimulus
        adf_pkg::cfg_t settings;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        settings.hihi_limit = q16(100);
        settings.high_limit = q16(50);
        settings.low_limit = q16(-50);
        settings.lolo_limit = q16(-100);
        settings.hysteresis = 31'(q16(5));
        settings.alarm_modes = {adf_pkg::SEL_ALL, adf_pkg::SEV_MINOR, adf_pkg::SEV_MINOR,
                                adf_pkg::SEV_MAJOR, adf_pkg::SEV_MAJOR};
        settings.value_deadband = 31'(q16(1));
        settings.archive_deadband = 31'(q16(10));
        apply_settings(settings);
        queue_item(q16(0), 1'b0, 16'd0, 8'h00);
        queue_item(q16(120), 1'b0, 16'd0, 8'h00);
        queue_item(q16(97), 1'b0, 16'd0, 8'h00);
        queue_item(q16(94), 1'b0, 16'd0, 8'h00);
        queue_item(q16(48), 1'b0, 16'd0, 8'h00);
        queue_item(q16(44), 1'b0, 16'd0, 8'h00);
        queue_item(q16(-120), 1'b0, 16'd0, 8'h00);
        queue_item(q16(-97), 1'b0, 16'd0, 8'h00);
        queue_item(q16(-60), 1'b0, 16'd0, 8'h00);
        queue_item(q16(-46), 1'b0, 16'd0, 8'h00);
        queue_item(q16(0), 1'b0, 16'd0, 8'h81);
        queue_item(32'sh7FFFFFFF, 1'b1, 16'hFFFF, 8'hFF);
        queue_item(32'sh7FFFFFFF, 1'b0, 16'd0, 8'h00);
        queue_item(32'sh80000000, 1'b0, 16'd0, 8'h00);
        queue_item(q16(0), 1'b0, 16'd0, 8'h00);
        wait_idle();

        settings.alarm_modes = {adf_pkg::SEL_NUMBER, adf_pkg::SEV_MINOR, adf_pkg::SEV_MINOR,
                                adf_pkg::SEV_MAJOR, adf_pkg::SEV_MAJOR};
        apply_settings(settings);
        queue_item(q16(1), 1'b0, 16'd0, 8'hFF);
        queue_item(q16(2), 1'b0, 16'd1, 8'h01);
        queue_item(q16(3), 1'b0, 16'd8, 8'h01);
        queue_item(q16(4), 1'b0, 16'd9, 8'h00);
        queue_item(q16(5), 1'b0, 16'hFFFF, 8'h00);
        wait_idle();

        settings.alarm_modes = {adf_pkg::SEL_BITMASK, adf_pkg::SEV_MINOR, adf_pkg::SEV_MINOR,
                                adf_pkg::SEV_MAJOR, adf_pkg::SEV_MAJOR};
        apply_settings(settings);
        queue_item(q16(0), 1'b0, 16'hFF00, 8'hFF);
        queue_item(q16(0), 1'b0, 16'h00A5, 8'h04);
        queue_item(q16(120), 1'b0, 16'h00A5, 8'h01);
        wait_idle();

        settings.alarm_modes = {adf_pkg::SEL_INVALID, adf_pkg::SEV_NONE, adf_pkg::SEV_NONE,
                                adf_pkg::SEV_NONE, adf_pkg::SEV_NONE};
        settings.hysteresis = '0;
        apply_settings(settings);
        queue_item(q16(200), 1'b0, 16'd3, 8'hFF);
        queue_item(q16(-200), 1'b1, 16'd3, 8'h00);
        wait_idle();

        settings.hihi_limit = q16($urandom_range(80, 120));
        settings.high_limit = q16($urandom_range(40, 60));
        settings.low_limit = -q16($urandom_range(40, 60));
        settings.lolo_limit = -q16($urandom_range(80, 120));
        settings.hysteresis = 31'(q16($urandom_range(1, 10)));
        settings.alarm_modes = {adf_pkg::SEL_ALL, 8'($urandom)};
        settings.value_deadband = 31'($urandom_range(0, 1 << 18));
        settings.archive_deadband = 31'($urandom_range(0, 1 << 22));
        apply_settings(settings);
        queue_random_items(RANDOM_PER_PHASE);
        wait_idle();

        settings.hihi_limit = 32'sh7FFFFFFF;
        settings.high_limit = '0;
        settings.low_limit = '0;
        settings.lolo_limit = 32'sh80000000;
        settings.hysteresis = 31'h7FFFFFFF;
        settings.alarm_modes = {adf_pkg::SEL_BITMASK, adf_pkg::SEV_INVALID, adf_pkg::SEV_MINOR,
                                adf_pkg::SEV_INVALID, adf_pkg::SEV_MAJOR};
        settings.value_deadband = 31'h7FFFFFFF;
        settings.archive_deadband = '0;
        apply_settings(settings);
        queue_random_items(RANDOM_PER_PHASE);
        wait_idle();

        settings.hihi_limit = $urandom;
        settings.high_limit = $urandom;
        settings.low_limit = $urandom;
        settings.lolo_limit = $urandom;
        settings.hysteresis = 31'($urandom_range(0, 1 << 20));
        settings.alarm_modes = {adf_pkg::SEL_NUMBER, 8'($urandom)};
        settings.value_deadband = '0;
        settings.archive_deadband = 31'(q16(5));
        apply_settings(settings);
        queue_random_items(RANDOM_PER_PHASE);
        wait_idle();

        settings.hihi_limit = $urandom;
        settings.high_limit = $urandom;
        settings.low_limit = $urandom;
        settings.lolo_limit = $urandom;
        settings.hysteresis = 31'($urandom);
        settings.alarm_modes = 10'($urandom);
        settings.value_deadband = 31'($urandom);
        settings.archive_deadband = 31'($urandom);
        apply_settings(settings);
        queue_random_items(RANDOM_PER_PHASE);
        wait_idle();

        if (predicted_results.size() != 0)
            report_mismatch("predicted transactions never seen", predicted_results.size(), '0);
        $display("Sent %0d transactions under %0d register settings, checked %0d results.",
                 accepted_total, settings_count, results_checked);
        $display("Covered alarm levels with hysteresis, undefined samples, all select modes,");
        $display("link failures, deadband events and a long result hold-off.");
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
